// File: design/whp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package whp_pkg;

  localparam int MaxChannels = 8;
  localparam int MaskBits = 11;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE, PH_FMT, PH_FMTX, PH_SKIP, PH_DATA, PH_ERR
  } phase_t;

  typedef enum logic [2:0] {
    KIND_FORMAT = 3'd0, KIND_SAMPLE = 3'd1, KIND_RAW = 3'd2, KIND_ERROR = 3'd3, KIND_END = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ERR_RIFF = 4'd0, ERR_WAVE = 4'd1, ERR_FORMAT = 4'd2, ERR_MULTI = 4'd3, ERR_GUID = 4'd4,
    ERR_LAYOUT = 4'd5, ERR_NOFMT = 4'd6, ERR_FLOAT = 4'd7, ERR_TRUNC = 4'd8
  } err_t;

  localparam logic [31:0] TagRiff = 32'h52494646;
  localparam logic [31:0] TagRf64 = 32'h52463634;
  localparam logic [31:0] TagWave = 32'h57415645;
  localparam logic [31:0] TagData = 32'h64617461;
  localparam logic [31:0] TagFmt = 32'h666D7420;
  localparam logic [15:0] WfPcm = 16'h0001;
  localparam logic [15:0] WfFloat = 16'h0003;
  localparam logic [15:0] WfAlaw = 16'h0006;
  localparam logic [15:0] WfUlaw = 16'h0007;
  localparam logic [15:0] WfExt = 16'hFFFE;
  localparam logic [31:0] Unsupported = 32'h000000C0;

  // Operation handed from the parser to the output stage.
  typedef enum logic [2:0] {
    OP_FORMAT, OP_SAMPLE_A, OP_SAMPLE_U, OP_RAW, OP_ERROR, OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        eos;
    logic        trunc;
    logic [7:0]  data;
    err_t        err;
    logic [1:0]  fc;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [15:0] vbits;
    logic [31:0] mask;
    logic [15:0] block;
    logic [31:0] dlen;
  } cmd_t;

  function automatic logic [7:0] guid_tail(input logic [3:0] g);
    case (g)
      4'd6: guid_tail = 8'h10;
      4'd8: guid_tail = 8'h80;
      4'd11: guid_tail = 8'haa;
      4'd13: guid_tail = 8'h38;
      4'd14: guid_tail = 8'h9b;
      4'd15: guid_tail = 8'h71;
      default: guid_tail = 8'h00;
    endcase
  endfunction

  function automatic logic [15:0] alaw(input logic [7:0] b);
    logic [7:0] v;
    logic [2:0] seg;
    logic [15:0] t;
    v = b ^ 8'h55;
    seg = v[6:4];
    t = {8'd0, v[3:0], 4'd0};
    if (seg == 3'd0) t = t + 16'd8;
    else t = (t + 16'h0108) << (seg - 3'd1);
    alaw = v[7] ? t : 16'(-t);
  endfunction

  function automatic logic [15:0] ulaw(input logic [7:0] b);
    logic [7:0] v;
    logic [15:0] t;
    v = ~b;
    t = ({9'd0, v[3:0], 3'd0} + 16'h0084) << v[6:4];
    ulaw = v[7] ? 16'(16'h0084 - t) : 16'(t - 16'h0084);
  endfunction

  function automatic logic layout_ok(input logic [31:0] mask, input logic [15:0] ch);
    logic [4:0] cpos;
    logic bad;
    bad = 1'b0;
    cpos = '0;
    if (ch < 16'd1 || ch > 16'(MaxChannels)) begin
      layout_ok = 1'b0;
    end else if (mask == '0) begin
      layout_ok = ch <= 16'd2;
    end else begin
      for (int i = 0; i < MaskBits; i++) begin
        if (mask[i] && (16'(cpos) < ch)) begin
          if (Unsupported[i]) bad = 1'b1;
          cpos = cpos + 5'd1;
        end
      end
      layout_ok = !bad && (16'(cpos) == ch);
    end
  endfunction

endpackage
`default_nettype wire

// File: design/whp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
module whp_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      data_byte,
  input  wire logic            end_of_stream,
  output logic                 cmd_valid,
  input  wire logic            cmd_full,
  output whp_pkg::cmd_t        cmd
);
  import whp_pkg::*;

  phase_t phase, phase_next;
  logic [4:0] idx, idx_next;
  logic [31:0] tag, tag_next, rem, rem_next, rate, rate_next, mask, mask_next;
  logic [15:0] fcode, fcode_next, chans, chans_next, blk, blk_next;
  logic [15:0] bits, bits_next, vbits, vbits_next;
  logic [1:0] gflags, gflags_next;
  logic have, have_next;
  logic acc;

  assign in_stall = cmd_full;
  assign acc = in_valid && !cmd_full;

  always_comb begin
    logic [31:0] r1, t1;
    logic [1:0] g1;
    logic [4:0] i1;
    logic [3:0] gi;
    logic [7:0] b;
    r1 = '0; t1 = '0; g1 = '0; i1 = '0; gi = '0;
    b = data_byte;
    phase_next = phase; idx_next = idx; tag_next = tag; rem_next = rem;
    rate_next = rate; mask_next = mask; fcode_next = fcode; chans_next = chans;
    blk_next = blk; bits_next = bits; vbits_next = vbits; gflags_next = gflags;
    have_next = have;
    cmd = '0;
    cmd.op = OP_NONE;
    cmd.data = b;
    cmd.eos = end_of_stream;
    unique case (phase)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID: begin
        t1 = {tag[23:0], b};
        tag_next = t1;
        idx_next = {3'd0, idx[1:0] + 2'd1};
        if (idx[1:0] == 2'd3) begin
          if (phase == PH_RIFF) begin
            if (t1 != TagRiff && t1 != TagRf64) begin
              cmd.op = OP_ERROR; cmd.err = ERR_RIFF; phase_next = PH_ERR;
            end else phase_next = PH_RSIZE;
          end else if (phase == PH_RSIZE) phase_next = PH_WAVE;
          else if (phase == PH_WAVE) begin
            if (t1 != TagWave) begin
              cmd.op = OP_ERROR; cmd.err = ERR_WAVE; phase_next = PH_ERR;
            end else phase_next = PH_CID;
          end else phase_next = PH_CSIZE;
        end
      end
      PH_CSIZE: begin
        r1 = rem;
        r1[8*idx[1:0] +: 8] = b;
        rem_next = r1;
        idx_next = {3'd0, idx[1:0] + 2'd1};
        if (idx[1:0] == 2'd3) begin
          if (tag == TagData) begin
            cmd.dlen = r1; cmd.channels = chans; cmd.rate = rate; cmd.bits = bits;
            cmd.block = blk;
            cmd.vbits = (fcode == WfExt) ? vbits : bits;
            cmd.mask = (fcode == WfExt) ? mask : '0;
            cmd.op = OP_FORMAT;
            phase_next = PH_DATA;
            if (fcode == WfPcm) cmd.fc = 2'd0;
            else if (fcode == WfFloat) cmd.fc = 2'd1;
            else if (fcode == WfAlaw) cmd.fc = 2'd2;
            else if (fcode == WfUlaw) cmd.fc = 2'd3;
            else if (fcode == WfExt && gflags[0]) cmd.fc = 2'd0;
            else if (fcode == WfExt && gflags[1]) cmd.fc = 2'd1;
            else begin cmd.op = OP_ERROR; cmd.err = ERR_GUID; end
            if (cmd.op == OP_FORMAT && cmd.fc == 2'd1 && bits != 16'd32) begin
              cmd.op = OP_ERROR; cmd.err = ERR_FLOAT;
            end
            if (!have) begin cmd.op = OP_ERROR; cmd.err = ERR_NOFMT; end
            if (cmd.op == OP_ERROR) phase_next = PH_ERR;
          end else if (tag == TagFmt) phase_next = PH_FMT;
          else phase_next = (r1 == '0) ? PH_CID : PH_SKIP;
        end
      end
      PH_FMT: begin
        r1 = (rem != '0) ? rem - 32'd1 : rem;
        rem_next = r1;
        idx_next = idx + 5'd1;
        if (idx < 5'd2) begin
          if (idx == 5'd0) fcode_next = {8'd0, b};
          else begin
            fcode_next = {b, fcode[7:0]};
            if (fcode_next != WfPcm && fcode_next != WfFloat && fcode_next != WfAlaw &&
                fcode_next != WfUlaw && fcode_next != WfExt) begin
              cmd.op = OP_ERROR; cmd.err = ERR_FORMAT; phase_next = PH_ERR;
            end
          end
        end else if (idx < 5'd4) chans_next[8*idx[0] +: 8] = b;
        else if (idx < 5'd8) rate_next[8*idx[1:0] +: 8] = b;
        else if (idx < 5'd12) begin
        end else if (idx < 5'd14) blk_next[8*idx[0] +: 8] = b;
        else begin
          bits_next[8*idx[0] +: 8] = b;
          if (idx == 5'd15) begin
            idx_next = '0;
            if (chans > 16'd2 && fcode != WfExt) begin
              cmd.op = OP_ERROR; cmd.err = ERR_MULTI; phase_next = PH_ERR;
            end else if (fcode == WfExt) phase_next = PH_FMTX;
            else if (!layout_ok('0, chans)) begin
              cmd.op = OP_ERROR; cmd.err = ERR_LAYOUT; phase_next = PH_ERR;
            end else begin
              have_next = 1'b1; phase_next = (r1 == '0) ? PH_CID : PH_SKIP;
            end
          end
        end
      end
      PH_FMTX: begin
        r1 = (rem != '0) ? rem - 32'd1 : rem;
        rem_next = r1;
        i1 = idx + 5'd1;
        idx_next = i1;
        if (idx < 5'd2) begin
        end else if (idx < 5'd4) vbits_next[8*idx[0] +: 8] = b;
        else if (idx < 5'd8) mask_next[8*idx[1:0] +: 8] = b;
        else begin
          gi = 4'(idx - 5'd8);
          g1 = gflags;
          if (gi == 4'd0) g1 = {b == 8'h03, b == 8'h01};
          else if (b != guid_tail(gi)) g1 = 2'b00;
          gflags_next = g1;
          if (gi == 4'd15) begin
            idx_next = '0;
            if (g1 == 2'b00) begin
              cmd.op = OP_ERROR; cmd.err = ERR_GUID; phase_next = PH_ERR;
            end else if (!layout_ok(mask, chans)) begin
              cmd.op = OP_ERROR; cmd.err = ERR_LAYOUT; phase_next = PH_ERR;
            end else begin
              have_next = 1'b1; phase_next = (r1 == '0) ? PH_CID : PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        r1 = (rem != '0) ? rem - 32'd1 : rem;
        rem_next = r1;
        if (r1 == '0) begin phase_next = PH_CID; idx_next = '0; end
      end
      PH_DATA: begin
        if (fcode == WfAlaw) cmd.op = OP_SAMPLE_A;
        else if (fcode == WfUlaw) cmd.op = OP_SAMPLE_U;
        else cmd.op = OP_RAW;
      end
      PH_ERR: begin
      end
      default: phase_next = PH_ERR;
    endcase
    cmd.trunc = end_of_stream && phase_next != PH_DATA && phase_next != PH_ERR;
    if (end_of_stream) begin
      phase_next = PH_RIFF; idx_next = '0; tag_next = '0; rem_next = '0;
      fcode_next = '0; chans_next = '0; rate_next = '0; blk_next = '0;
      bits_next = '0; vbits_next = '0; mask_next = '0; gflags_next = 2'b11;
      have_next = 1'b0;
    end
  end

  assign cmd_valid = acc && (cmd.op != OP_NONE || end_of_stream);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIFF; idx <= '0; tag <= '0; rem <= '0; fcode <= '0; chans <= '0;
      rate <= '0; blk <= '0; bits <= '0; vbits <= '0; mask <= '0; gflags <= 2'b11;
      have <= 1'b0;
    end else if (acc) begin
      phase <= phase_next; idx <= idx_next; tag <= tag_next; rem <= rem_next;
      fcode <= fcode_next; chans <= chans_next; rate <= rate_next; blk <= blk_next;
      bits <= bits_next; vbits <= vbits_next; mask <= mask_next; gflags <= gflags_next;
      have <= have_next;
    end
  end
endmodule
`default_nettype wire

// File: design/whp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module whp_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_valid,
  output logic             full,
  input  wire whp_pkg::cmd_t wr_cmd,
  output logic             rd_valid,
  input  wire logic        rd_take,
  output whp_pkg::cmd_t    rd_cmd
);
  import whp_pkg::*;

  cmd_t slots [2];
  logic wp, rp;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_cmd = slots[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && !full) slots[wp] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= '0;
    end else begin
      if (wr_valid && !full) wp <= ~wp;
      if (rd_take) rp <= ~rp;
      count <= count + 2'(wr_valid && !full) - 2'(rd_take);
    end
  end
endmodule
`default_nettype wire

// File: design/whp_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
module whp_emitter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_take,
  input  wire whp_pkg::cmd_t cmd,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         kind,
  output logic signed [15:0] sample,
  output logic [1:0]         format_code,
  output logic [15:0]        channel_count,
  output logic [31:0]        sample_rate,
  output logic [15:0]        container_bits,
  output logic [15:0]        valid_bits,
  output logic [31:0]        speaker_mask,
  output logic [15:0]        block_align,
  output logic [31:0]        data_length,
  output logic [3:0]         error_code
);
  import whp_pkg::*;

  // Sub-step within one request: main result, truncation error, end marker.
  logic [1:0] step, step_next;
  logic emit, last, load;
  logic [2:0] k;
  logic [15:0] s;
  logic [3:0] e;

  always_comb begin
    step_next = step;
    emit = 1'b0;
    last = 1'b0;
    k = KIND_END; s = '0; e = '0;
    if (step == 2'd0) begin
      if (cmd.op != OP_NONE) begin
        emit = 1'b1;
        case (cmd.op)
          OP_FORMAT: k = KIND_FORMAT;
          OP_SAMPLE_A: begin k = KIND_SAMPLE; s = alaw(cmd.data); end
          OP_SAMPLE_U: begin k = KIND_SAMPLE; s = ulaw(cmd.data); end
          OP_RAW: begin k = KIND_RAW; s = {8'd0, cmd.data}; end
          default: begin k = KIND_ERROR; e = cmd.err; end
        endcase
        last = !cmd.eos;
        step_next = 2'd1;
      end else step_next = 2'd1;
    end else if (step == 2'd1) begin
      if (cmd.trunc) begin
        emit = 1'b1; k = KIND_ERROR; e = ERR_TRUNC; step_next = 2'd2;
      end else begin
        emit = 1'b1; k = KIND_END; last = 1'b1;
      end
    end else begin
      emit = 1'b1; k = KIND_END; last = 1'b1;
    end
  end

  assign load = cmd_valid && (!out_valid || !out_stall);
  assign cmd_take = load && (last || (step == 2'd0 && cmd.op == OP_NONE && !cmd.eos));

  always_ff @(posedge clk) begin
    if (load && emit) begin
      kind <= k; sample <= s; error_code <= e;
      if (k == KIND_FORMAT) begin
        format_code <= cmd.fc; channel_count <= cmd.channels; sample_rate <= cmd.rate;
        container_bits <= cmd.bits; valid_bits <= cmd.vbits; speaker_mask <= cmd.mask;
        block_align <= cmd.block; data_length <= cmd.dlen;
      end else begin
        format_code <= '0; channel_count <= '0; sample_rate <= '0; container_bits <= '0;
        valid_bits <= '0; speaker_mask <= '0; block_align <= '0; data_length <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; step <= '0;
    end else begin
      if (load) out_valid <= emit;
      else if (!out_stall) out_valid <= 1'b0;
      if (load) step <= cmd_take ? 2'd0 : step_next;
    end
  end
endmodule
`default_nettype wire

// File: design/wave_header_parser_g711_stream_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake           Payload
// input    in_valid/in_stall   data_byte, end_of_stream
// output   out_valid/out_stall kind, sample, format_code ... error_code
// One byte is accepted per cycle while in_stall is low; each request passes a two-entry queue.
// A byte ending the stream yields up to three results and holds its queue
// entry until the last of them is loaded into the output register.
// Each result is registered in the queue and then in the output register.
// Reset clears the parser state and empties the queue and output register.
module wave_header_parser_g711_stream_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_stream,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         kind,
  output logic signed [15:0] sample,
  output logic [1:0]         format_code,
  output logic [15:0]        channel_count,
  output logic [31:0]        sample_rate,
  output logic [15:0]        container_bits,
  output logic [15:0]        valid_bits,
  output logic [31:0]        speaker_mask,
  output logic [15:0]        block_align,
  output logic [31:0]        data_length,
  output logic [3:0]         error_code
);
  import whp_pkg::*;

  cmd_t pcmd, qcmd;
  logic pvalid, full, qvalid, take;

  whp_parser u_parser (
    .clk, .rst, .in_valid, .in_stall, .data_byte, .end_of_stream,
    .cmd_valid(pvalid), .cmd_full(full), .cmd(pcmd)
  );

  whp_queue u_queue (
    .clk, .rst, .wr_valid(pvalid), .full, .wr_cmd(pcmd),
    .rd_valid(qvalid), .rd_take(take), .rd_cmd(qcmd)
  );

  whp_emitter u_emitter (
    .clk, .rst, .cmd_valid(qvalid), .cmd_take(take), .cmd(qcmd),
    .out_valid, .out_stall, .kind, .sample, .format_code, .channel_count,
    .sample_rate, .container_bits, .valid_bits, .speaker_mask, .block_align,
    .data_length, .error_code
  );

  a_take_valid: assert property (@(posedge clk) disable iff (rst) take |-> qvalid)
    else $error("queue taken while empty");
  a_stall_full: assert property (@(posedge clk) disable iff (rst) in_stall == full)
    else $error("input stall differs from queue full");
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_ERROR |-> error_code == 4'd0)
    else $error("error code on a non-error result");
endmodule
`default_nettype wire
